// File: rtl/core/sst_pkg.sv
package sst_pkg;

    // Sign plus digit characters at or beyond this count are rejected
    localparam int MAX_PREFIX = 128;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int PLEN_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int ACC_W    = VALUE_W + 4;

    localparam logic [VALUE_W-1:0] CAP_MAG = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [PLEN_W-1:0]  PLEN_MAX = 8'hFF;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_B     = 8'h62;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
    localparam logic [CHAR_W-1:0] CH_K     = 8'h6B;
    localparam logic [CHAR_W-1:0] CH_M     = 8'h6D;

    // Decimal units and binary unit shifts
    localparam logic [VALUE_W-1:0] MUL_K = 64'd1000;
    localparam logic [VALUE_W-1:0] MUL_M = 64'd1000000;
    localparam logic [VALUE_W-1:0] MUL_G = 64'd1000000000;
    localparam int SHIFT_KI = 10;
    localparam int SHIFT_MI = 20;
    localparam int SHIFT_GI = 30;

    typedef enum logic [2:0] {
        PH_SIGN   = 3'b001,
        PH_DIGIT  = 3'b010,
        PH_SUFFIX = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        U_ONE,
        U_KILO,
        U_KIBI,
        U_MEGA,
        U_MEBI,
        U_GIGA,
        U_GIBI,
        U_BAD
    } t_unit;

    // Parser state as seen by the result stage. The scaled sums hold
    // min(digits * unit, 2^63) for the decimal units.
    typedef struct packed {
        logic                 negative;
        logic                 digit_seen;
        logic [PLEN_W-1:0]    prefix_len;
        logic [CHAR_W-1:0]    suf_a;
        logic [CHAR_W-1:0]    suf_b;
        logic [1:0]           suf_len;
        logic [VALUE_W-1:0]   mag;
        logic [VALUE_W-1:0]   mag_k;
        logic [VALUE_W-1:0]   mag_m;
        logic [VALUE_W-1:0]   mag_g;
    } t_parse_state;

    // s*10 + d*unit, held at 2^63
    function automatic logic [VALUE_W-1:0] acc_step(
        input logic [VALUE_W-1:0] s,
        input logic [DIGIT_W-1:0] d,
        input logic [VALUE_W-1:0] unit
    );
        logic [ACC_W-1:0] t;
        t = (ACC_W'(s) << 3) + (ACC_W'(s) << 1) + ACC_W'(d) * ACC_W'(unit);
        return (t > ACC_W'(CAP_MAG)) ? CAP_MAG : t[VALUE_W-1:0];
    endfunction

    // m << n, held at 2^63
    function automatic logic [VALUE_W-1:0] sat_shift(
        input logic [VALUE_W-1:0] m,
        input int                 n
    );
        return ((m >> (VALUE_W - 1 - n)) != '0) ? CAP_MAG : (m << n);
    endfunction

endpackage

// File: rtl/core/size_string_to_integer.sv
// Size string parser. Characters arrive one per request on the slave side,
// and a request with tlast high ends the string (its tdata is ignored). The
// string is an optional minus, decimal digits, and an optional unit suffix
// matched without regard to case: b, k = 1000, kb = 1024, m, mb, g, gb. The
// end request produces one result: the signed value times the unit,
// saturated to 64 bits, with tuser high and value 0 for a malformed string
// (unknown suffix, sign without digits, or sign plus digits of MAX_PREFIX
// characters or more). An empty string or a bare unit gives 0. One request is
// taken every cycle while the result side keeps up; an end request waits in
// the input register while the previous result has not been taken yet. The
// result of an end request goes from the input register into the result
// register. The per-character step is a 68-bit times-ten add and clamp,
// run in parallel for the plain value and the three decimal units, so the
// end request needs only a select, a binary-unit shift, a clamp and a negate.
module size_string_to_integer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sst_pkg::CHAR_W-1:0]  s_axis_tdata,  // [7:0] ch
    input  logic                        s_axis_tlast,  // is_end
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sst_pkg::VALUE_W-1:0] m_axis_tdata,  // [63:0] value
    output logic                        m_axis_tuser   // [0] bad_format
);

    logic                          r_in_valid;
    logic [sst_pkg::CHAR_W-1:0]    r_in_ch;
    logic                          r_in_end;

    logic                          out_free;
    logic                          step;
    sst_pkg::t_parse_state         state;

    // A character always advances; an end request waits for the result slot
    assign step          = r_in_valid && (!r_in_end || out_free);
    assign s_axis_tready = !r_in_valid || step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ch  <= s_axis_tdata;
            r_in_end <= s_axis_tlast;
        end
    end

    sst_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char_en (step && !r_in_end),
        .i_end_en  (step && r_in_end),
        .i_ch      (r_in_ch),
        .o_state   (state)
    );

    sst_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && r_in_end),
        .i_state (state),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_value (m_axis_tdata),
        .o_bad   (m_axis_tuser)
    );

endmodule

// File: rtl/core/sst_parse.sv
module sst_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_char_en,
    input  logic                       i_end_en,
    input  logic [sst_pkg::CHAR_W-1:0] i_ch,
    output sst_pkg::t_parse_state      o_state
);

    sst_pkg::t_phase        r_phase, n_phase;
    sst_pkg::t_parse_state  r_st, n_st;

    logic                          is_digit;
    logic [sst_pkg::DIGIT_W-1:0]   digit;
    logic [sst_pkg::CHAR_W-1:0]    low_ch;
    logic [sst_pkg::CHAR_W-1:0]    ch_off;
    logic                          take_digit;
    logic                          take_sign;
    logic                          take_suffix;

    // Character classes
    always_comb begin
        ch_off   = i_ch - sst_pkg::CH_ZERO;
        is_digit = (i_ch >= sst_pkg::CH_ZERO) && (i_ch <= sst_pkg::CH_NINE);
        digit    = ch_off[sst_pkg::DIGIT_W-1:0];
        low_ch   = ((i_ch >= sst_pkg::CH_UP_A) && (i_ch <= sst_pkg::CH_UP_Z))
                   ? (i_ch + sst_pkg::CH_CASE) : i_ch;
    end

    // What this character does, by phase
    always_comb begin
        take_digit  = 1'b0;
        take_sign   = 1'b0;
        take_suffix = 1'b0;
        case (r_phase)
            sst_pkg::PH_SIGN: begin
                if (i_ch == sst_pkg::CH_MINUS) begin
                    take_sign = 1'b1;
                end else if (is_digit) begin
                    take_digit = 1'b1;
                end else begin
                    take_suffix = 1'b1;
                end
            end
            sst_pkg::PH_DIGIT: begin
                if (is_digit) begin
                    take_digit = 1'b1;
                end else begin
                    take_suffix = 1'b1;
                end
            end
            default: begin
                take_suffix = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_st    = r_st;
        if (i_end_en) begin
            n_phase = sst_pkg::PH_SIGN;
            n_st    = '0;
        end else if (i_char_en) begin
            if (take_sign || take_digit) begin
                n_phase = sst_pkg::PH_DIGIT;
                if (r_st.prefix_len != sst_pkg::PLEN_MAX) begin
                    n_st.prefix_len = r_st.prefix_len + 1'b1;
                end
            end
            if (take_sign) begin
                n_st.negative = 1'b1;
            end
            // Plain and decimal-scaled sums advance together
            if (take_digit) begin
                n_st.digit_seen = 1'b1;
                n_st.mag   = sst_pkg::acc_step(r_st.mag, digit, 64'd1);
                n_st.mag_k = sst_pkg::acc_step(r_st.mag_k, digit, sst_pkg::MUL_K);
                n_st.mag_m = sst_pkg::acc_step(r_st.mag_m, digit, sst_pkg::MUL_M);
                n_st.mag_g = sst_pkg::acc_step(r_st.mag_g, digit, sst_pkg::MUL_G);
            end
            // Keep the first two suffix characters, count up to three
            if (take_suffix) begin
                n_phase = sst_pkg::PH_SUFFIX;
                if (r_st.suf_len == 2'd0) begin
                    n_st.suf_a = low_ch;
                end
                if (r_st.suf_len == 2'd1) begin
                    n_st.suf_b = low_ch;
                end
                if (r_st.suf_len != 2'd3) begin
                    n_st.suf_len = r_st.suf_len + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sst_pkg::PH_SIGN;
            r_st    <= '0;
        end else begin
            r_phase <= n_phase;
            r_st    <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

// File: rtl/core/sst_finish.sv
module sst_finish (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  sst_pkg::t_parse_state       i_state,
    input  logic                        i_ready,
    output logic                        o_free,
    output logic                        o_valid,
    output logic [sst_pkg::VALUE_W-1:0] o_value,
    output logic                        o_bad
);

    sst_pkg::t_unit                unit;
    logic [sst_pkg::VALUE_W-1:0]   scaled;
    logic [sst_pkg::VALUE_W-1:0]   lim;
    logic [sst_pkg::VALUE_W-1:0]   prod;
    logic [sst_pkg::VALUE_W-1:0]   n_value;
    logic                          n_bad;

    logic                          r_valid;
    logic [sst_pkg::VALUE_W-1:0]   r_value;
    logic                          r_bad;

    // Suffix decode
    always_comb begin
        unit = sst_pkg::U_BAD;
        case (i_state.suf_len)
            2'd0: begin
                unit = sst_pkg::U_ONE;
            end
            2'd1: begin
                if (i_state.suf_a == sst_pkg::CH_B) unit = sst_pkg::U_ONE;
                if (i_state.suf_a == sst_pkg::CH_K) unit = sst_pkg::U_KILO;
                if (i_state.suf_a == sst_pkg::CH_M) unit = sst_pkg::U_MEGA;
                if (i_state.suf_a == sst_pkg::CH_G) unit = sst_pkg::U_GIGA;
            end
            2'd2: begin
                if (i_state.suf_b == sst_pkg::CH_B) begin
                    if (i_state.suf_a == sst_pkg::CH_K) unit = sst_pkg::U_KIBI;
                    if (i_state.suf_a == sst_pkg::CH_M) unit = sst_pkg::U_MEBI;
                    if (i_state.suf_a == sst_pkg::CH_G) unit = sst_pkg::U_GIBI;
                end
            end
            default: begin
                unit = sst_pkg::U_BAD;
            end
        endcase
    end

    // Pick the scaled magnitude, clamp to the signed range, apply the sign
    always_comb begin
        case (unit)
            sst_pkg::U_KILO: scaled = i_state.mag_k;
            sst_pkg::U_MEGA: scaled = i_state.mag_m;
            sst_pkg::U_GIGA: scaled = i_state.mag_g;
            sst_pkg::U_KIBI: scaled = sst_pkg::sat_shift(i_state.mag, sst_pkg::SHIFT_KI);
            sst_pkg::U_MEBI: scaled = sst_pkg::sat_shift(i_state.mag, sst_pkg::SHIFT_MI);
            sst_pkg::U_GIBI: scaled = sst_pkg::sat_shift(i_state.mag, sst_pkg::SHIFT_GI);
            default:         scaled = i_state.mag;
        endcase
        lim   = i_state.negative ? sst_pkg::CAP_MAG : sst_pkg::POS_MAX;
        prod  = (scaled > lim) ? lim : scaled;
        n_bad = (unit == sst_pkg::U_BAD)
                || (i_state.prefix_len >= sst_pkg::PLEN_W'(sst_pkg::MAX_PREFIX))
                || (i_state.negative && !i_state.digit_seen);
        if (n_bad) begin
            n_value = '0;
        end else if (i_state.negative) begin
            n_value = '0 - prod;
        end else begin
            n_value = prod;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
            r_bad   <= n_bad;
        end
    end

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_bad   = r_bad;

endmodule

// File: tb/size_string_to_integer_test.sv
`timescale 1ns / 100ps

module size_string_to_integer_test;

    typedef struct {
        logic [sst_pkg::VALUE_W-1:0] value;
        logic                        bad_format;
    } t_size_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [sst_pkg::CHAR_W-1:0]  s_axis_tdata = '0;   // [7:0] ch
    logic                        s_axis_tlast = 1'b0; // is_end
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [sst_pkg::VALUE_W-1:0] m_axis_tdata;        // [63:0] value
    logic                        m_axis_tuser;        // [0] bad_format

    // Parser mirror
    sst_pkg::t_phase             prs_phase;
    logic                        prs_negative;
    logic [sst_pkg::VALUE_W-1:0] prs_mag;
    logic                        prs_overflow;
    logic [sst_pkg::PLEN_W-1:0]  prs_prefix_len;
    logic                        prs_digit_seen;
    logic [sst_pkg::CHAR_W-1:0]  prs_suf_a;
    logic [sst_pkg::CHAR_W-1:0]  prs_suf_b;
    logic [1:0]                  prs_suf_len;

    t_size_result expected_sizes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int strings_sent = 0;
    int chars_sent = 0;
    int results_checked = 0;
    int mismatches = 0;

    size_string_to_integer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // Parser prediction
    // ---------------------------------------------------------------
    function automatic void clear_parser();
        prs_phase      = sst_pkg::PH_SIGN;
        prs_negative   = 1'b0;
        prs_mag        = '0;
        prs_overflow   = 1'b0;
        prs_prefix_len = '0;
        prs_digit_seen = 1'b0;
        prs_suf_a      = '0;
        prs_suf_b      = '0;
        prs_suf_len    = '0;
    endfunction

    function automatic void count_prefix();
        if (prs_prefix_len != sst_pkg::PLEN_MAX) begin
            prs_prefix_len = prs_prefix_len + 1'b1;
        end
    endfunction

    // Accumulate one digit, pinned at 2^63 once it runs past
    function automatic void take_digit(input logic [sst_pkg::CHAR_W-1:0] c);
        logic [sst_pkg::VALUE_W-1:0] d;
        d = sst_pkg::VALUE_W'(c - sst_pkg::CH_ZERO);
        prs_digit_seen = 1'b1;
        count_prefix();
        if (prs_overflow || prs_mag > (sst_pkg::CAP_MAG - d) / 10) begin
            prs_overflow = 1'b1;
            prs_mag = sst_pkg::CAP_MAG;
        end else begin
            prs_mag = prs_mag * 10 + d;
        end
    endfunction

    // Keep the first two suffix characters, lowered
    function automatic void take_suffix(input logic [sst_pkg::CHAR_W-1:0] c);
        if (c >= sst_pkg::CH_UP_A && c <= sst_pkg::CH_UP_Z) begin
            c = c + sst_pkg::CH_CASE;
        end
        prs_phase = sst_pkg::PH_SUFFIX;
        if (prs_suf_len == 2'd0) begin
            prs_suf_a = c;
        end else if (prs_suf_len == 2'd1) begin
            prs_suf_b = c;
        end
        if (prs_suf_len != 2'd3) begin
            prs_suf_len = prs_suf_len + 1'b1;
        end
    endfunction

    // Zero means the suffix is not a unit
    function automatic logic [sst_pkg::VALUE_W-1:0] suffix_unit();
        if (prs_suf_len == 2'd0) begin
            return 64'd1;
        end
        if (prs_suf_len == 2'd1) begin
            case (prs_suf_a)
                sst_pkg::CH_B: return 64'd1;
                sst_pkg::CH_K: return sst_pkg::MUL_K;
                sst_pkg::CH_M: return sst_pkg::MUL_M;
                sst_pkg::CH_G: return sst_pkg::MUL_G;
                default:       return 64'd0;
            endcase
        end
        if (prs_suf_len == 2'd2 && prs_suf_b == sst_pkg::CH_B) begin
            case (prs_suf_a)
                sst_pkg::CH_K: return 64'd1 << sst_pkg::SHIFT_KI;
                sst_pkg::CH_M: return 64'd1 << sst_pkg::SHIFT_MI;
                sst_pkg::CH_G: return 64'd1 << sst_pkg::SHIFT_GI;
                default:       return 64'd0;
            endcase
        end
        return 64'd0;
    endfunction

    function automatic void predict_request(input logic [sst_pkg::CHAR_W-1:0] c,
                                            input logic last);
        logic [sst_pkg::VALUE_W-1:0] unit;
        logic [sst_pkg::VALUE_W-1:0] lim;
        logic [sst_pkg::VALUE_W-1:0] mag;
        logic [sst_pkg::VALUE_W-1:0] prod;
        logic                        is_digit;
        t_size_result                res;
        is_digit = (c >= sst_pkg::CH_ZERO && c <= sst_pkg::CH_NINE);
        if (!last) begin
            case (prs_phase)
                sst_pkg::PH_SIGN: begin
                    if (c == sst_pkg::CH_MINUS) begin
                        prs_negative = 1'b1;
                        count_prefix();
                        prs_phase = sst_pkg::PH_DIGIT;
                    end else if (is_digit) begin
                        prs_phase = sst_pkg::PH_DIGIT;
                        take_digit(c);
                    end else begin
                        take_suffix(c);
                    end
                end
                sst_pkg::PH_DIGIT: begin
                    if (is_digit) begin
                        take_digit(c);
                    end else begin
                        take_suffix(c);
                    end
                end
                default: take_suffix(c);
            endcase
            return;
        end
        // Terminator: scale, saturate, sign
        unit = suffix_unit();
        res.bad_format = (unit == 0) || (prs_prefix_len >= sst_pkg::MAX_PREFIX) ||
                         (prs_negative && !prs_digit_seen);
        res.value = '0;
        if (!res.bad_format) begin
            lim  = prs_negative ? sst_pkg::CAP_MAG : sst_pkg::POS_MAX;
            mag  = (prs_overflow || prs_mag > lim) ? lim : prs_mag;
            prod = (mag > lim / unit) ? lim : mag * unit;
            res.value = prs_negative ? (64'd0 - prod) : prod;
        end
        expected_sizes.push_back(res);
        clear_parser();
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stall and compare
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_size_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_sizes.size() == 0) begin
                $error("unexpected result: value %0d bad_format %0b",
                       $signed(m_axis_tdata), m_axis_tuser);
                mismatches++;
            end else begin
                want = expected_sizes.pop_front();
                results_checked++;
                if (m_axis_tdata !== want.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(want.value), $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser !== want.bad_format) begin
                    $error("bad_format: expected %0b, got %0b",
                           want.bad_format, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    task automatic send_item(input logic [sst_pkg::CHAR_W-1:0] c, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(c, last);
        if (last) begin
            strings_sent++;
        end else begin
            chars_sent++;
        end
    endtask

    // Characters then the terminator; the terminator's data is don't-care
    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_digits(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            send_item(8'(sst_pkg::CH_ZERO + $urandom_range(9)), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_units();
        send_string("1");
        send_string("1b");
        send_string("2k");
        send_string("3KB");
        send_string("4m");
        send_string("5Mb");
        send_string("6g");
        send_string("-7gB");
    endtask

    task automatic test_empty_and_sign();
        send_string("");
        send_string("kb");
        send_string("-");
        send_string("-k");
        send_string("-0");
    endtask

    task automatic test_bad_suffix();
        send_string("1x");
        send_string("1kbb");
        send_string("1k5");
        send_string("2k-");
        send_string("3bb");
        // zero byte is just another non-digit
        send_item(8'h00, 1'b0);
        send_string("");
        send_item(8'hFF, 1'b0);
        send_string("");
    endtask

    task automatic test_saturation();
        send_string("9223372036854775807");
        send_string("9223372036854775808");
        send_string("-9223372036854775808");
        send_string("-9223372036854775809");
        send_string("99999999999999999999999");
        send_string("9223372036854775807gb");
        send_string("-9999999999999999G");
        send_string("8589934592GB");
    endtask

    // Signed prefix one below and right at the limit, and past the 8-bit hold
    task automatic test_long_prefix();
        send_item(sst_pkg::CH_MINUS, 1'b0);
        send_digits(sst_pkg::MAX_PREFIX - 2);
        send_string("k");
        send_item(sst_pkg::CH_MINUS, 1'b0);
        send_digits(sst_pkg::MAX_PREFIX - 1);
        send_string("");
        send_digits(260);
        send_string("b");
    endtask

    // Mostly well-formed strings, some broken suffixes, some raw noise
    task automatic test_random_strings(input int send_pct, input int recv_pct,
                                       input int n_chars);
        string units[8];
        string letters;
        string u;
        int    stop_at;
        int    kind;
        int    n;
        int    i;
        logic [sst_pkg::CHAR_W-1:0] c;
        units = '{"", "b", "k", "kb", "m", "mb", "g", "gb"};
        letters = "bkmgBKMG";
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 92) begin
                if ($urandom_range(3) == 0) begin
                    send_item(sst_pkg::CH_MINUS, 1'b0);
                end
                if ($urandom_range(59) == 0) begin
                    n = $urandom_range(sst_pkg::MAX_PREFIX - 3, sst_pkg::MAX_PREFIX + 2);
                end else if ($urandom_range(9) == 0) begin
                    n = $urandom_range(13, 30);
                end else begin
                    n = $urandom_range(0, 12);
                end
                send_digits(n);
                u = units[$urandom_range(7)];
                for (i = 0; i < u.len(); i++) begin
                    c = u[i];
                    if ($urandom_range(1) == 1) begin
                        c = c - sst_pkg::CH_CASE;
                    end
                    send_item(c, 1'b0);
                end
                // broken tail after the unit
                if (kind >= 80) begin
                    n = $urandom_range(1, 3);
                    for (i = 0; i < n; i++) begin
                        case ($urandom_range(3))
                            0: c = letters[$urandom_range(7)];
                            1: c = 8'(sst_pkg::CH_ZERO + $urandom_range(9));
                            2: c = sst_pkg::CH_MINUS;
                            default: c = 8'($urandom_range(255));
                        endcase
                        send_item(c, 1'b0);
                    end
                end
            end else begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++) begin
                    send_item(8'($urandom_range(255)), 1'b0);
                end
            end
            send_item(8'($urandom_range(255)), 1'b1);
        end
    endtask

    initial begin
        clear_parser();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_units();
        test_empty_and_sign();
        test_bad_suffix();
        test_saturation();
        test_long_prefix();
        test_random_strings(0, 0, 130);
        test_random_strings(73, 0, 110);
        test_random_strings(0, 73, 110);
        test_random_strings(20, 20, 110);

        s_axis_tvalid <= 1'b0;
        while (expected_sizes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("tb: %0d strings, %0d characters, %0d results compared",
                 strings_sent, chars_sent, results_checked);
        $display("tb: units, signs, bad suffixes, saturation, prefix limit, random mixes");
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/sst_pkg.sv
rtl/core/sst_parse.sv
rtl/core/sst_finish.sv
rtl/core/size_string_to_integer.sv
tb/size_string_to_integer_test.sv
